// ----- rtl/plbu_pkg.sv -----
`default_nettype none

package plbu_pkg;

  // Default sizes of the book.
  localparam int LEVELS_DEF     = 64;
  localparam int PRICE_BITS_DEF = 32;
  localparam int QTY_BITS_DEF   = 32;

  // Fixed widths of the fields on the streaming ports.
  localparam int FIELD_PRICE_W = 32;
  localparam int FIELD_QTY_W   = 32;
  localparam int SYMBOL_W      = 16;
  localparam int IN_TDATA_W    = 80;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 128;
  localparam int OUT_TUSER_W   = 3;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_BOOK_SYMBOL = 1'b0;

  typedef enum logic {
    SIDE_BID = 1'b0,
    SIDE_ASK = 1'b1
  } plbu_side_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_COPY,
    ST_PUT,
    ST_POST,
    ST_PSCAN,
    ST_PNEXT,
    ST_DONE
  } plbu_state_t;

  // Port controls of one side's level table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } plbu_mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/plbu_side.sv -----
`default_nettype none

// Level table of one side: price and quantity memories with one read and
// one write port, plus a copy of entry 0 that is kept up to date on writes.
module plbu_side #(
  parameter int LEVELS     = plbu_pkg::LEVELS_DEF,
  parameter int PRICE_BITS = plbu_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS   = plbu_pkg::QTY_BITS_DEF,
  localparam int IDX_W     = $clog2(LEVELS)
) (
  input  wire logic                    clk,
  input  wire plbu_pkg::plbu_mem_ctl_t ctl,
  input  wire logic [IDX_W-1:0]        rd_addr,
  input  wire logic [IDX_W-1:0]        wr_addr,
  input  wire logic [PRICE_BITS-1:0]   wr_price,
  input  wire logic [QTY_BITS-1:0]     wr_qty,
  output logic      [PRICE_BITS-1:0]   rd_price,
  output logic      [QTY_BITS-1:0]     rd_qty,
  output logic      [PRICE_BITS-1:0]   head_price,
  output logic      [QTY_BITS-1:0]     head_qty
);

  logic [PRICE_BITS-1:0] price_mem [LEVELS];
  logic [QTY_BITS-1:0]   qty_mem   [LEVELS];
  logic [PRICE_BITS-1:0] rd_price_r;
  logic [QTY_BITS-1:0]   rd_qty_r;
  logic [PRICE_BITS-1:0] head_price_r;
  logic [QTY_BITS-1:0]   head_qty_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      price_mem[wr_addr] <= wr_price;
      qty_mem[wr_addr]   <= wr_qty;
    end
    if (ctl.rd_en) begin
      rd_price_r <= price_mem[rd_addr];
      rd_qty_r   <= qty_mem[rd_addr];
    end
  end

  // The best level is always entry 0, so a write there refreshes the copy.
  always_ff @(posedge clk) begin
    if (ctl.wr_en && (wr_addr == '0)) begin
      head_price_r <= wr_price;
      head_qty_r   <= wr_qty;
    end
  end

  assign rd_price   = rd_price_r;
  assign rd_qty     = rd_qty_r;
  assign head_price = head_price_r;
  assign head_qty   = head_qty_r;

endmodule

`default_nettype wire

// ----- rtl/price_level_book_update.sv -----
// Price-level book. The block holds a bid table (highest price first) and an
// ask table (lowest price first) of up to LEVELS_PER_SIDE levels each, and
// answers every input word with one result word carrying the top of book.
// A word with a nonzero price and quantity inserts or overwrites that level,
// a zero quantity erases it, and a word with tlast set then removes crossed
// levels: bids at or above the best ask and asks at or below the best bid,
// both taken before the prune. A word whose symbol check fails is dropped
// whole and flagged; a new price on a full side is dropped and flagged.
// Timing: the block takes one word at a time and is not ready again until
// that word's result has been loaded into the output register, which waits
// while an earlier result is still held there. A word rejected by the symbol
// check goes straight to the result, and a word with a zero price skips the
// scan and goes to the prune check. Otherwise the scan walks from the best
// level to the slot of the price; an overwrite then writes that slot, an
// erase of an absent price or a dropped new price writes nothing, an erase
// closes the slot by moving the worse levels up and an insert opens it by
// moving them down and then writes the new level. A prune scans the crossed
// levels at the front of each side, moves the kept levels up when anything
// is crossed, and then changes side. The pace is set by the single
// comparator that walks the sorted table one level per cycle and by the one
// read and one write port of each table, through which levels are moved one
// per cycle when a slot is opened or closed. No clearing pass is needed
// after reset: only entries below the fill count are ever compared or moved.
`default_nettype none

module price_level_book_update #(
  parameter int LEVELS_PER_SIDE = plbu_pkg::LEVELS_DEF,
  parameter int PRICE_BITS      = plbu_pkg::PRICE_BITS_DEF,
  parameter int QTY_BITS        = plbu_pkg::QTY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream.
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // level_price [31:0], level_qty [63:32], item_symbol [79:64]
  input  wire logic [plbu_pkg::IN_TDATA_W-1:0]   in_tdata,
  // side [0], check_symbol [1]
  input  wire logic [plbu_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire logic                              in_tlast,
  // Result stream.
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // best_bid_price [31:0], best_bid_qty [63:32],
  // best_ask_price [95:64], best_ask_qty [127:96]
  output logic      [plbu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // top_valid [0], symbol_error [1], table_overflow [2]
  output logic      [plbu_pkg::OUT_TUSER_W-1:0]  out_tuser,
  // Configuration port.
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [plbu_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [plbu_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [plbu_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int IDX_W = $clog2(LEVELS_PER_SIDE);
  localparam int CNT_W = $clog2(LEVELS_PER_SIDE + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LEVELS_PER_SIDE);

  // ---------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------
  logic [plbu_pkg::SYMBOL_W-1:0] sym_r;
  logic                          cfg_hit;
  logic                          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[plbu_pkg::CFG_ADDR_W-1:2] == plbu_pkg::REG_BOOK_SYMBOL);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? plbu_pkg::CFG_DATA_W'(sym_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r <= '0;
    end else if (cfg_wr) begin
      sym_r <= cfg_pwdata[plbu_pkg::SYMBOL_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Input word fields. Prices and quantities are taken to the internal
  // widths, which masks them as the book defines.
  // ---------------------------------------------------------------------
  logic [63:0]                   in_price_ext;
  logic [63:0]                   in_qty_ext;
  logic [PRICE_BITS-1:0]         in_price;
  logic [QTY_BITS-1:0]           in_qty;
  logic [plbu_pkg::SYMBOL_W-1:0] in_sym;
  logic                          sym_bad;

  assign in_price_ext = 64'(in_tdata[31:0]);
  assign in_qty_ext   = 64'(in_tdata[63:32]);
  assign in_price     = in_price_ext[PRICE_BITS-1:0];
  assign in_qty       = in_qty_ext[QTY_BITS-1:0];
  assign in_sym       = in_tdata[79:64];
  assign sym_bad      = in_tuser[1] && (in_sym != sym_r);

  // ---------------------------------------------------------------------
  // Level tables.
  // ---------------------------------------------------------------------
  plbu_pkg::plbu_mem_ctl_t ctl_b;
  plbu_pkg::plbu_mem_ctl_t ctl_a;
  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        wr_addr;
  logic [PRICE_BITS-1:0]   wr_price;
  logic [QTY_BITS-1:0]     wr_qty;
  logic                    rd_en;
  logic                    wr_en;
  logic [PRICE_BITS-1:0]   rd_price_b, rd_price_a, head_price_b, head_price_a;
  logic [QTY_BITS-1:0]     rd_qty_b, rd_qty_a, head_qty_b, head_qty_a;

  // ---------------------------------------------------------------------
  // Sequencer registers.
  // ---------------------------------------------------------------------
  plbu_pkg::plbu_state_t state_r, state_nxt;
  plbu_pkg::plbu_side_t  side_r, side_nxt;
  logic [CNT_W-1:0]      bid_cnt_r, bid_cnt_nxt;
  logic [CNT_W-1:0]      ask_cnt_r, ask_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [QTY_BITS-1:0]   qty_r, qty_nxt;
  logic [PRICE_BITS-1:0] key_r, key_nxt;
  logic [PRICE_BITS-1:0] pb_r, pb_nxt;
  logic                  eou_r, eou_nxt;
  logic                  prune_r, prune_nxt;
  logic                  eq_r, eq_nxt;
  logic                  put_r, put_nxt;
  logic                  dir_r, dir_nxt;
  logic                  pend_r, pend_nxt;
  logic                  sym_err_r, sym_err_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]      src_r, src_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      pdst_r, pdst_nxt;
  logic [plbu_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [plbu_pkg::OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // The one shared comparator: the level just read against the key.
  logic [PRICE_BITS-1:0] cur_rd_price;
  logic [QTY_BITS-1:0]   cur_rd_qty;
  logic [CNT_W-1:0]      cur_cnt;
  logic                  cmp_gt, cmp_lt, cmp_eq, cont;

  assign cur_rd_price = (side_r == plbu_pkg::SIDE_ASK) ? rd_price_a : rd_price_b;
  assign cur_rd_qty   = (side_r == plbu_pkg::SIDE_ASK) ? rd_qty_a : rd_qty_b;
  assign cur_cnt      = (side_r == plbu_pkg::SIDE_ASK) ? ask_cnt_r : bid_cnt_r;
  assign cmp_gt       = cur_rd_price > key_r;
  assign cmp_lt       = cur_rd_price < key_r;
  assign cmp_eq       = cur_rd_price == key_r;
  // Keep walking while the level is strictly better than the key; during a
  // prune an equal price is crossed as well.
  assign cont = (side_r == plbu_pkg::SIDE_BID) ? (cmp_gt || (prune_r && cmp_eq))
                                               : (cmp_lt || (prune_r && cmp_eq));

  // Top of book as it stands now, widened or cut to the port fields.
  logic [63:0] top_bp, top_bq, top_ap, top_aq;

  assign top_bp = (bid_cnt_r != '0) ? 64'(head_price_b) : '0;
  assign top_bq = (bid_cnt_r != '0) ? 64'(head_qty_b) : '0;
  assign top_ap = (ask_cnt_r != '0) ? 64'(head_price_a) : '0;
  assign top_aq = (ask_cnt_r != '0) ? 64'(head_qty_a) : '0;

  assign in_tready = (state_r == plbu_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    bid_cnt_nxt   = bid_cnt_r;
    ask_cnt_nxt   = ask_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    price_nxt     = price_r;
    qty_nxt       = qty_r;
    key_nxt       = key_r;
    pb_nxt        = pb_r;
    eou_nxt       = eou_r;
    prune_nxt     = prune_r;
    eq_nxt        = eq_r;
    put_nxt       = put_r;
    dir_nxt       = dir_r;
    pend_nxt      = pend_r;
    sym_err_nxt   = sym_err_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    src_nxt       = src_r;
    rem_nxt       = rem_r;
    pdst_nxt      = pdst_r;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    rd_en         = 1'b1;
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_price      = price_r;
    wr_qty        = qty_r;

    unique case (state_r)
      plbu_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          price_nxt   = in_price;
          qty_nxt     = in_qty;
          key_nxt     = in_price;
          eou_nxt     = in_tlast;
          side_nxt    = plbu_pkg::plbu_side_t'(in_tuser[0]);
          prune_nxt   = 1'b0;
          put_nxt     = 1'b0;
          sym_err_nxt = 1'b0;
          ovf_nxt     = 1'b0;
          idx_nxt     = '0;
          priority if (sym_bad) begin
            sym_err_nxt = 1'b1;
            state_nxt   = plbu_pkg::ST_DONE;
          end else if (in_price == '0) begin
            state_nxt = plbu_pkg::ST_POST;
          end else begin
            state_nxt = plbu_pkg::ST_SCAN;
          end
        end
      end

      // Walk from the best level to the first one not better than the price.
      plbu_pkg::ST_SCAN: begin
        priority if (idx_r >= cur_cnt) begin
          eq_nxt    = 1'b0;
          state_nxt = plbu_pkg::ST_ACT;
        end else if (cont) begin
          idx_nxt = idx_r + CNT_W'(1);
        end else begin
          eq_nxt    = cmp_eq;
          state_nxt = plbu_pkg::ST_ACT;
        end
      end

      plbu_pkg::ST_ACT: begin
        pend_nxt = 1'b0;
        priority if (eq_r && (qty_r != '0)) begin
          wr_en     = 1'b1;
          state_nxt = plbu_pkg::ST_POST;
        end else if (eq_r) begin
          // Erase: close the slot by moving the worse levels up by one.
          dir_nxt   = 1'b0;
          k_nxt     = CNT_W'(1);
          src_nxt   = idx_r + CNT_W'(1);
          rem_nxt   = cur_cnt - idx_r - CNT_W'(1);
          state_nxt = plbu_pkg::ST_COPY;
          if (side_r == plbu_pkg::SIDE_ASK) begin
            ask_cnt_nxt = ask_cnt_r - CNT_W'(1);
          end else begin
            bid_cnt_nxt = bid_cnt_r - CNT_W'(1);
          end
        end else if (qty_r == '0) begin
          state_nxt = plbu_pkg::ST_POST;
        end else if (cur_cnt == FULL) begin
          ovf_nxt   = 1'b1;
          state_nxt = plbu_pkg::ST_POST;
        end else begin
          // Insert: open the slot, moving from the worst level downwards.
          dir_nxt   = 1'b1;
          src_nxt   = cur_cnt - CNT_W'(1);
          rem_nxt   = cur_cnt - idx_r;
          put_nxt   = 1'b1;
          state_nxt = plbu_pkg::ST_COPY;
          if (side_r == plbu_pkg::SIDE_ASK) begin
            ask_cnt_nxt = ask_cnt_r + CNT_W'(1);
          end else begin
            bid_cnt_nxt = bid_cnt_r + CNT_W'(1);
          end
        end
      end

      // Move levels one per cycle: read one entry while writing the last.
      plbu_pkg::ST_COPY: begin
        rd_en = (rem_r != '0);
        if (rem_r != '0) begin
          pend_nxt = 1'b1;
          pdst_nxt = dir_r ? (src_r + CNT_W'(1)) : (src_r - k_r);
          src_nxt  = dir_r ? (src_r - CNT_W'(1)) : (src_r + CNT_W'(1));
          rem_nxt  = rem_r - CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          wr_en    = 1'b1;
          wr_addr  = pdst_r[IDX_W-1:0];
          wr_price = cur_rd_price;
          wr_qty   = cur_rd_qty;
        end
        if ((rem_r == '0) && !pend_r) begin
          priority if (put_r) begin
            state_nxt = plbu_pkg::ST_PUT;
          end else if (prune_r) begin
            state_nxt = plbu_pkg::ST_PNEXT;
          end else begin
            state_nxt = plbu_pkg::ST_POST;
          end
        end
      end

      plbu_pkg::ST_PUT: begin
        wr_en     = 1'b1;
        put_nxt   = 1'b0;
        state_nxt = plbu_pkg::ST_POST;
      end

      // Start the prune with both best prices taken before anything moves.
      plbu_pkg::ST_POST: begin
        if (eou_r && (bid_cnt_r != '0) && (ask_cnt_r != '0)) begin
          pb_nxt    = head_price_b;
          key_nxt   = head_price_a;
          side_nxt  = plbu_pkg::SIDE_BID;
          prune_nxt = 1'b1;
          idx_nxt   = '0;
          state_nxt = plbu_pkg::ST_PSCAN;
        end else begin
          state_nxt = plbu_pkg::ST_DONE;
        end
      end

      // Count the crossed levels at the front, then drop them in one move.
      plbu_pkg::ST_PSCAN: begin
        if ((idx_r >= cur_cnt) || !cont) begin
          if (idx_r == '0) begin
            state_nxt = plbu_pkg::ST_PNEXT;
          end else begin
            dir_nxt   = 1'b0;
            pend_nxt  = 1'b0;
            k_nxt     = idx_r;
            src_nxt   = idx_r;
            rem_nxt   = cur_cnt - idx_r;
            state_nxt = plbu_pkg::ST_COPY;
            if (side_r == plbu_pkg::SIDE_ASK) begin
              ask_cnt_nxt = ask_cnt_r - idx_r;
            end else begin
              bid_cnt_nxt = bid_cnt_r - idx_r;
            end
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end

      plbu_pkg::ST_PNEXT: begin
        if (side_r == plbu_pkg::SIDE_BID) begin
          side_nxt  = plbu_pkg::SIDE_ASK;
          key_nxt   = pb_r;
          idx_nxt   = '0;
          state_nxt = plbu_pkg::ST_PSCAN;
        end else begin
          state_nxt = plbu_pkg::ST_DONE;
        end
      end

      plbu_pkg::ST_DONE: begin
        rd_en = 1'b0;
        if (!out_valid_r || out_tready) begin
          out_tdata_nxt = {top_aq[31:0], top_ap[31:0], top_bq[31:0], top_bp[31:0]};
          out_tuser_nxt = {ovf_r, sym_err_r, (bid_cnt_r != '0) && (ask_cnt_r != '0)};
          out_valid_nxt = 1'b1;
          state_nxt     = plbu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = plbu_pkg::ST_IDLE;
      end
    endcase

    // Scans read ahead at the next index; the mover reads its source.
    rd_addr = ((state_r == plbu_pkg::ST_COPY) && (rem_r != '0)) ? src_r[IDX_W-1:0]
                                                                : idx_nxt[IDX_W-1:0];
  end

  always_comb begin
    ctl_b.rd_en = rd_en;
    ctl_a.rd_en = rd_en;
    ctl_b.wr_en = wr_en && (side_r == plbu_pkg::SIDE_BID);
    ctl_a.wr_en = wr_en && (side_r == plbu_pkg::SIDE_ASK);
  end

  plbu_side #(
    .LEVELS     (LEVELS_PER_SIDE),
    .PRICE_BITS (PRICE_BITS),
    .QTY_BITS   (QTY_BITS)
  ) u_bid (
    .clk        (clk),
    .ctl        (ctl_b),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_price   (wr_price),
    .wr_qty     (wr_qty),
    .rd_price   (rd_price_b),
    .rd_qty     (rd_qty_b),
    .head_price (head_price_b),
    .head_qty   (head_qty_b)
  );

  plbu_side #(
    .LEVELS     (LEVELS_PER_SIDE),
    .PRICE_BITS (PRICE_BITS),
    .QTY_BITS   (QTY_BITS)
  ) u_ask (
    .clk        (clk),
    .ctl        (ctl_a),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_price   (wr_price),
    .wr_qty     (wr_qty),
    .rd_price   (rd_price_a),
    .rd_qty     (rd_qty_a),
    .head_price (head_price_a),
    .head_qty   (head_qty_a)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plbu_pkg::ST_IDLE;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      put_r       <= 1'b0;
      prune_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bid_cnt_r   <= bid_cnt_nxt;
      ask_cnt_r   <= ask_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      put_r       <= put_nxt;
      prune_r     <= prune_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r      <= side_nxt;
    price_r     <= price_nxt;
    qty_r       <= qty_nxt;
    key_r       <= key_nxt;
    pb_r        <= pb_nxt;
    eou_r       <= eou_nxt;
    eq_r        <= eq_nxt;
    dir_r       <= dir_nxt;
    sym_err_r   <= sym_err_nxt;
    ovf_r       <= ovf_nxt;
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    src_r       <= src_nxt;
    rem_r       <= rem_nxt;
    pdst_r      <= pdst_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bid_cnt_r <= FULL) && (ask_cnt_r <= FULL))
    else $error("level count beyond table depth");

  a_sym_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && sym_bad) |=> ($stable(bid_cnt_r) && $stable(ask_cnt_r)))
    else $error("rejected word changed the book");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[1] && out_tuser[2]))
    else $error("symbol error and overflow flagged together");

  a_top_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> ((out_tdata[31:0] != '0) && (out_tdata[95:64] != '0)))
    else $error("valid top of book with a zero price");

  a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == plbu_pkg::ST_COPY) && pend_r) |-> (pdst_r < FULL))
    else $error("level move outside the table");

endmodule

`default_nettype wire

// ----- tb/price_level_book_checker.sv -----
`default_nettype none

module price_level_book_checker #(
  parameter int LEVELS = plbu_pkg::LEVELS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  // level_price [31:0], level_qty [63:32], item_symbol [79:64]
  input  wire logic [plbu_pkg::IN_TDATA_W-1:0]  in_tdata,
  // side [0], check_symbol [1]
  input  wire logic [plbu_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                             in_tlast,
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  // best_bid_price [31:0], best_bid_qty [63:32],
  // best_ask_price [95:64], best_ask_qty [127:96]
  input  wire logic [plbu_pkg::OUT_TDATA_W-1:0] out_tdata,
  // top_valid [0], symbol_error [1], table_overflow [2]
  input  wire logic [plbu_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic                             cfg_pready,
  input  wire logic [plbu_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [plbu_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output int                                    fail_count,
  output int                                    pending_count,
  output int                                    checked_count,
  output int                                    overflow_count,
  output int                                    reject_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import plbu_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] BOOK_SYMBOL_ADDR = {REG_BOOK_SYMBOL, 2'b00};

  typedef struct packed {
    logic [31:0] bid_px;
    logic [31:0] bid_qt;
    logic [31:0] ask_px;
    logic [31:0] ask_qt;
    logic        top_valid;
    logic        symbol_error;
    logic        overflow;
  } book_top_t;

  logic [SYMBOL_W-1:0] accepted_symbol;
  logic [31:0]         level_px [2][LEVELS];
  logic [31:0]         level_qt [2][LEVELS];
  int                  level_n  [2];
  book_top_t           top_q [$];
  int                  reported;

  // Strictly better position in the table: higher for bids, lower for asks.
  function automatic bit ranks_ahead(plbu_side_t s, logic [31:0] a, logic [31:0] b);
    return (s == SIDE_BID) ? (a > b) : (a < b);
  endfunction

  function automatic int find_slot(plbu_side_t s, logic [31:0] p);
    int i;
    i = 0;
    while (i < level_n[s] && ranks_ahead(s, level_px[s][i], p)) i++;
    return i;
  endfunction

  // Returns 1 when a new price finds its side full and is dropped.
  function automatic bit put_level(plbu_side_t s, logic [31:0] p, logic [31:0] q);
    int i;
    int j;
    i = find_slot(s, p);
    if (i < level_n[s] && level_px[s][i] == p) begin
      level_qt[s][i] = q;
      return 1'b0;
    end
    if (level_n[s] >= LEVELS) return 1'b1;
    for (j = level_n[s]; j > i; j--) begin
      level_px[s][j] = level_px[s][j-1];
      level_qt[s][j] = level_qt[s][j-1];
    end
    level_px[s][i] = p;
    level_qt[s][i] = q;
    level_n[s]++;
    return 1'b0;
  endfunction

  function automatic void drop_level(plbu_side_t s, logic [31:0] p);
    int i;
    int j;
    i = find_slot(s, p);
    if (i < level_n[s] && level_px[s][i] == p) begin
      for (j = i; j < level_n[s] - 1; j++) begin
        level_px[s][j] = level_px[s][j+1];
        level_qt[s][j] = level_qt[s][j+1];
      end
      level_n[s]--;
    end
  endfunction

  function automatic void drop_front(plbu_side_t s, int k);
    int j;
    for (j = 0; j < level_n[s] - k; j++) begin
      level_px[s][j] = level_px[s][j+k];
      level_qt[s][j] = level_qt[s][j+k];
    end
    level_n[s] -= k;
  endfunction

  // Both best prices are latched before either side loses a level.
  function automatic void prune_crossed();
    logic [31:0] best_bid;
    logic [31:0] best_ask;
    int          kb;
    int          ka;
    if (level_n[SIDE_BID] == 0 || level_n[SIDE_ASK] == 0) return;
    best_bid = level_px[SIDE_BID][0];
    best_ask = level_px[SIDE_ASK][0];
    kb = 0;
    ka = 0;
    while (kb < level_n[SIDE_BID] && level_px[SIDE_BID][kb] >= best_ask) kb++;
    while (ka < level_n[SIDE_ASK] && level_px[SIDE_ASK][ka] <= best_bid) ka++;
    drop_front(SIDE_BID, kb);
    drop_front(SIDE_ASK, ka);
  endfunction

  function automatic book_top_t apply_word(plbu_side_t s, logic [31:0] p, logic [31:0] q,
                                           logic eou, logic chk, logic [SYMBOL_W-1:0] sym);
    book_top_t t;
    t.symbol_error = chk && (sym != accepted_symbol);
    t.overflow     = 1'b0;
    if (!t.symbol_error) begin
      if (p != 32'd0) begin
        if (q != 32'd0) t.overflow = put_level(s, p, q);
        else drop_level(s, p);
      end
      if (eou) prune_crossed();
    end
    t.bid_px    = (level_n[SIDE_BID] != 0) ? level_px[SIDE_BID][0] : 32'd0;
    t.bid_qt    = (level_n[SIDE_BID] != 0) ? level_qt[SIDE_BID][0] : 32'd0;
    t.ask_px    = (level_n[SIDE_ASK] != 0) ? level_px[SIDE_ASK][0] : 32'd0;
    t.ask_qt    = (level_n[SIDE_ASK] != 0) ? level_qt[SIDE_ASK][0] : 32'd0;
    t.top_valid = (level_n[SIDE_BID] != 0) && (level_n[SIDE_ASK] != 0);
    return t;
  endfunction

  initial begin
    fail_count     = 0;
    pending_count  = 0;
    checked_count  = 0;
    overflow_count = 0;
    reject_count   = 0;
    reported       = 0;
  end

  always @(posedge clk) begin
    book_top_t got;
    book_top_t want;
    if (!rst_n) begin
      accepted_symbol    = '0;
      level_n[SIDE_BID]  = 0;
      level_n[SIDE_ASK]  = 0;
    end else begin
      // Results first: a result can never belong to a word taken in the same cycle.
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tdata[127:96],
               out_tuser[0], out_tuser[1], out_tuser[2]};
        if (top_q.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%t: result word with nothing outstanding: %h", $realtime, got);
          end
        end else begin
          want = top_q.pop_front();
          checked_count++;
          if (got.bid_px !== want.bid_px || got.bid_qt !== want.bid_qt ||
              got.ask_px !== want.ask_px || got.ask_qt !== want.ask_qt ||
              got.top_valid !== want.top_valid || got.symbol_error !== want.symbol_error ||
              got.overflow !== want.overflow) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%t: top of book mismatch", $realtime);
              $display("  expected bid %h x %h ask %h x %h valid %b symerr %b ovf %b",
                       want.bid_px, want.bid_qt, want.ask_px, want.ask_qt,
                       want.top_valid, want.symbol_error, want.overflow);
              $display("  actual   bid %h x %h ask %h x %h valid %b symerr %b ovf %b",
                       got.bid_px, got.bid_qt, got.ask_px, got.ask_qt,
                       got.top_valid, got.symbol_error, got.overflow);
            end
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == BOOK_SYMBOL_ADDR)
        accepted_symbol = cfg_pwdata[SYMBOL_W-1:0];
      if (in_tvalid && in_tready) begin
        want = apply_word(plbu_side_t'(in_tuser[0]), in_tdata[31:0], in_tdata[63:32],
                          in_tlast, in_tuser[1], in_tdata[79:64]);
        if (want.overflow) overflow_count++;
        if (want.symbol_error) reject_count++;
        top_q.push_back(want);
      end
    end
    pending_count = top_q.size();
  end

endmodule

`default_nettype wire

// ----- tb/price_level_book_update_tb.sv -----
`default_nettype none

// Stimulus and verdict for the price-level book. A checker beside the block
// follows every accepted word on the input, configuration and result
// channels, keeps its own bid and ask tables, and counts any result that
// differs from its prediction. This module only makes traffic: a short
// directed run over the corner cases, then phases of random messages, each
// phase setting a book symbol, price centre and flow-control pattern.
module price_level_book_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plbu_pkg::*;

  localparam int WORDS_PER_PHASE = 200;
  localparam int PHASES          = 8;
  // The slowest word is an insert into a side one level short of full
  // followed by a prune that empties both full sides; it and the sender
  // gaps and receiver stalls at 71 in a hundred stay well under the limit,
  // so a run this long with no word moving can only mean the block has
  // hung.
  localparam int WATCHDOG_LIMIT  = 6000;
  // Drain time after the last result, with margin, to catch stray late results.
  localparam int DRAIN_CYCLES    = 600;

  localparam logic [CFG_ADDR_W-1:0] BOOK_SYMBOL_ADDR = {REG_BOOK_SYMBOL, 2'b00};

  typedef struct packed {
    plbu_side_t          side;
    logic [31:0]         price;
    logic [31:0]         qty;
    logic                eou;
    logic                check;
    logic [SYMBOL_W-1:0] symbol;
  } level_word_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;
  logic                   in_tlast    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int fail_count;
  int pending_count;
  int checked_count;
  int overflow_count;
  int reject_count;

  // Flow-control pattern of the current phase, in cycles per hundred.
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;

  logic [SYMBOL_W-1:0] book_symbol_now = '0;
  int words_sent     = 0;
  int directed_words = 0;
  int idle_cycles    = 0;

  price_level_book_update dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  price_level_book_checker book_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .overflow_count (overflow_count),
    .reject_count   (reject_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver decides afresh on every falling edge whether to stall.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: any accepted word on either stream restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic level_word_t lvl(plbu_side_t side, logic [31:0] price, logic [31:0] qty,
                                      logic eou, logic check, logic [SYMBOL_W-1:0] symbol);
    level_word_t w;
    w.side   = side;
    w.price  = price;
    w.qty    = qty;
    w.eou    = eou;
    w.check  = check;
    w.symbol = symbol;
    return w;
  endfunction

  // A word from the feed: half of them ask for the symbol check, and a tenth
  // of those carry a foreign symbol. Unchecked words carry any symbol at all.
  function automatic level_word_t feed_word(plbu_side_t side, logic [31:0] price,
                                            logic [31:0] qty, logic eou);
    logic                chk;
    logic [SYMBOL_W-1:0] sym;
    chk = 1'($urandom_range(1));
    if (!chk) sym = SYMBOL_W'($urandom_range(65535));
    else if ($urandom_range(99) < 10)
      sym = book_symbol_now ^ SYMBOL_W'($urandom_range(65535, 1));
    else sym = book_symbol_now;
    return lvl(side, price, qty, eou, chk, sym);
  endfunction

  // Mostly full-range or small quantities; zero only where an erase is wanted.
  function automatic logic [31:0] pick_qty(bit allow_zero);
    int          r;
    logic [31:0] q;
    r = $urandom_range(99);
    if (allow_zero && r < 20) q = 32'd0;
    else if (r < 60) q = $urandom;
    else q = $urandom_range(1000, 1);
    if (!allow_zero && q == 32'd0) q = 32'd1;
    return q;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so a following word keeps it up without a dip.
  task automatic send_word(input level_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w.symbol, w.qty, w.price};
    in_tuser  <= {w.check, w.side};
    in_tlast  <= w.eou;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic write_book_symbol(input logic [SYMBOL_W-1:0] sym);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= BOOK_SYMBOL_ADDR;
    // The upper half of the bus is noise that the register must not keep.
    cfg_pwdata  <= {16'($urandom_range(65535)), sym};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    book_symbol_now = sym;
  endtask

  // Registers are only touched once every outstanding result has come back.
  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    level_word_t d [$];
    int i;
    d.push_back(lvl(SIDE_BID, 32'd100, 32'd5, 1'b0, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_ASK, 32'd200, 32'd7, 1'b0, 1'b1, 16'h0000));
    // Unchecked word with a foreign symbol is still applied; extreme values.
    d.push_back(lvl(SIDE_BID, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'hFFFF));
    // Zero price is ignored, but its end of update still prunes the cross.
    d.push_back(lvl(SIDE_ASK, 32'd0, 32'd12, 1'b1, 1'b1, 16'h0000));
    // Symbol mismatch: the whole word is dropped, prune included.
    d.push_back(lvl(SIDE_BID, 32'd300, 32'd1, 1'b1, 1'b1, 16'h1234));
    // Erase of a price that is not held.
    d.push_back(lvl(SIDE_ASK, 32'd555, 32'd0, 1'b0, 1'b1, 16'h0000));
    // Overwrite, then inserts below and above, then erase from the middle.
    d.push_back(lvl(SIDE_BID, 32'd100, 32'd9, 1'b0, 1'b0, 16'h5A5A));
    d.push_back(lvl(SIDE_BID, 32'd150, 32'd3, 1'b0, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_BID, 32'd120, 32'd4, 1'b0, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_BID, 32'd120, 32'd0, 1'b0, 1'b1, 16'h0000));
    // An ask below every bid empties both sides in one prune.
    d.push_back(lvl(SIDE_ASK, 32'd90, 32'd2, 1'b1, 1'b1, 16'h0000));
    // Prune with the bid side empty changes nothing.
    d.push_back(lvl(SIDE_ASK, 32'd50, 32'd1, 1'b1, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_ASK, 32'd300, 32'd1, 1'b0, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_ASK, 32'd250, 32'd2, 1'b0, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_ASK, 32'd400, 32'hFFFF_FFFF, 1'b0, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_BID, 32'd240, 32'd1, 1'b0, 1'b1, 16'h0000));
    // A partial cross: both bids and the two lowest asks go, the higher asks stay.
    d.push_back(lvl(SIDE_BID, 32'd260, 32'd2, 1'b1, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_BID, 32'd1, 32'd1, 1'b0, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_ASK, 32'd1, 32'd0, 1'b0, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_BID, 32'd0, 32'd0, 1'b0, 1'b1, 16'h0000));
    d.push_back(lvl(SIDE_ASK, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1, 16'h0000));
    // A bid just under the top price sweeps all asks but the highest.
    d.push_back(lvl(SIDE_BID, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0000));
    for (i = 0; i < d.size(); i++) send_word(d[i]);
    directed_words = d.size();
  endtask

  // One market message: mostly well-formed updates around the centre price,
  // some crossing levels that force a prune, the odd burst that fills a side
  // past its capacity, and a share of arbitrary noise.
  task automatic run_message(input logic [31:0] mid);
    int          kind;
    int          len;
    int          k;
    int          base;
    plbu_side_t  s;
    logic [31:0] p;
    logic [31:0] off;
    kind = $urandom_range(99);
    s    = plbu_side_t'($urandom_range(1));
    if (kind < 62) begin
      len = $urandom_range(6, 1);
      for (k = 0; k < len; k++) begin
        s   = plbu_side_t'($urandom_range(1));
        off = $urandom_range(90, 1);
        p   = (s == SIDE_BID) ? mid - off : mid + off;
        send_word(feed_word(s, p, pick_qty(1'b1), k == len - 1));
      end
    end else if (kind < 77) begin
      off = $urandom_range(60, 0);
      p   = (s == SIDE_BID) ? mid + off : mid - off;
      send_word(feed_word(s, p, pick_qty(1'b0), 1'b1));
    end else if (kind < 80) begin
      // Seventy distinct new prices cannot all fit in one side.
      base = $urandom_range(20, 1);
      for (k = 0; k < 70; k++) begin
        p = (s == SIDE_BID) ? mid - 32'(base + k) : mid + 32'(base + k);
        send_word(lvl(s, p, pick_qty(1'b0), 1'b0, 1'b0, SYMBOL_W'($urandom_range(65535))));
      end
    end else begin
      len = $urandom_range(3, 1);
      for (k = 0; k < len; k++) begin
        s    = plbu_side_t'($urandom_range(1));
        kind = $urandom_range(99);
        if (kind < 15) p = 32'd0;
        else if (kind < 25) p = 32'hFFFF_FFFF;
        else p = $urandom;
        send_word(lvl(s, p, ($urandom_range(99) < 30) ? 32'd0 : $urandom,
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      ($urandom_range(1) != 0) ? book_symbol_now
                                               : SYMBOL_W'($urandom_range(65535))));
      end
    end
  endtask

  initial begin
    int          ph;
    int          first;
    logic [31:0] mid;
    logic [SYMBOL_W-1:0] sym;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The register resets to zero; writing zero again sets the low extreme.
    write_book_symbol(16'h0000);
    run_directed();

    for (ph = 0; ph < PHASES; ph++) begin
      wait_until_idle();
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
        default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
      endcase
      // Both symbol extremes and several values between them.
      if (ph == 0 || ph == 5) sym = 16'hFFFF;
      else if (ph == 3) sym = 16'h0000;
      else sym = SYMBOL_W'($urandom_range(65535));
      write_book_symbol(sym);
      // Price centres near the bottom and the top of the range make the
      // bands wrap; the rest sit anywhere in between.
      if (ph == 1) mid = 32'd40;
      else if (ph == 6) mid = 32'hFFFF_FFC0;
      else mid = $urandom_range(32'hFFFF_FF00, 32'd200);
      first = words_sent;
      while (words_sent - first < WORDS_PER_PHASE) run_message(mid);
    end

    wait_until_idle();
    receiver_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Drove %0d level words, %0d of them directed, over %0d symbol and flow phases.",
             words_sent, directed_words, PHASES);
    $display("Compared %0d top-of-book words: %0d with a dropped level, %0d with a bad symbol.",
             checked_count, overflow_count, reject_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
